// ----- design/smrk_pkg.sv -----
// Package: shared constants and controller/datapath command and status types.
package smrk_pkg;

  localparam int MAX_LISTS = 8;
  localparam int MAX_LEN   = 64;

  localparam int DATA_W    = 32;
  localparam int LIST_ID_W = 3;
  localparam int COUNT_W   = 4;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};
  localparam logic signed [DATA_W-1:0] INT_MAX = {1'b0, {(DATA_W-1){1'b1}}};

  typedef struct packed {
    logic accept;
    logic init_start;
    logic init_rd;
    logic init_wr;
    logic step;
    logic fetch;
    logic finish;
  } smrk_cmd_t;

  typedef struct packed {
    logic in_fire;
    logic in_last;
    logic empty_any;
    logic init_last;
    logic step_last;
    logic out_free;
  } smrk_status_t;

endpackage

// ----- design/smrk_in_if.sv -----
// Interface: input word channel (one list element per word).
interface smrk_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [smrk_pkg::LIST_ID_W-1:0]         list_id;
  logic signed [smrk_pkg::DATA_W-1:0]     elem_value;
  logic                                   set_done;

  modport source (output valid, output list_id, output elem_value, output set_done,
                  input ready);
  modport sink   (input valid, input list_id, input elem_value, input set_done,
                  output ready);
endinterface

// ----- design/smrk_out_if.sv -----
// Interface: result word channel.
interface smrk_out_if;
  logic                               valid;
  logic                               ready;
  logic [smrk_pkg::DATA_W-1:0]        range_width;
  logic signed [smrk_pkg::DATA_W-1:0] range_start;
  logic                               empty_list;
  logic                               overflowed;

  modport source (output valid, output range_width, output range_start,
                  output empty_list, output overflowed, input ready);
  modport sink   (input valid, input range_width, input range_start,
                  input empty_list, input overflowed, output ready);
endinterface

// ----- design/smrk_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module smrk_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 512,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/smrk_ctrl.sv -----
// Controller: sequences loading, head fetch, merge steps and result hand-off.
module smrk_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  smrk_pkg::smrk_status_t status_i,
  output smrk_pkg::smrk_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_CHECK,
    ST_INIT_RD,
    ST_INIT_WR,
    ST_MERGE,
    ST_FETCH,
    ST_FINISH
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_LOAD: begin
        cmd_o.accept = 1'b1;
        if (status_i.in_fire && status_i.in_last) state_d = ST_CHECK;
      end
      ST_CHECK: begin
        cmd_o.init_start = 1'b1;
        state_d = status_i.empty_any ? ST_FINISH : ST_INIT_RD;
      end
      ST_INIT_RD: begin
        cmd_o.init_rd = 1'b1;
        state_d = ST_INIT_WR;
      end
      ST_INIT_WR: begin
        cmd_o.init_wr = 1'b1;
        state_d = status_i.init_last ? ST_MERGE : ST_INIT_RD;
      end
      ST_MERGE: begin
        cmd_o.step = 1'b1;
        state_d = status_i.step_last ? ST_FINISH : ST_FETCH;
      end
      ST_FETCH: begin
        cmd_o.fetch = 1'b1;
        state_d = ST_MERGE;
      end
      ST_FINISH: begin
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- design/smrk_datapath.sv -----
// Datapath: list storage, head registers, min tree, running max, best range, result word.
module smrk_datapath #(
  parameter int MAX_LISTS = smrk_pkg::MAX_LISTS,
  parameter int MAX_LEN   = smrk_pkg::MAX_LEN
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [smrk_pkg::COUNT_W-1:0]    cfg_wdata_i,
  smrk_in_if.sink                         in_i,
  smrk_out_if.source                      out_o,
  input  smrk_pkg::smrk_cmd_t             cmd_i,
  output smrk_pkg::smrk_status_t          status_o
);

  localparam int DW    = smrk_pkg::DATA_W;
  localparam int LIW   = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int NL    = 1 << LIW;
  localparam int LW    = $clog2(MAX_LEN + 1);
  localparam int CW    = $clog2(MAX_LISTS + 1);
  localparam int DEPTH = MAX_LISTS * MAX_LEN;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [smrk_pkg::COUNT_W-1:0] list_count_q;
  logic [LW-1:0]                len_q [MAX_LISTS];
  logic [LW-1:0]                pos_q [MAX_LISTS];
  logic signed [DW-1:0]         head_q [MAX_LISTS];
  logic signed [DW-1:0]         max_q;
  logic [DW:0]                  best_w_q;
  logic signed [DW-1:0]         best_s_q;
  logic                         drop_q;
  logic [LIW-1:0]               idx_q;
  logic [LIW-1:0]               m_q;
  logic                         out_valid_q;
  logic [DW-1:0]                out_width_q;
  logic signed [DW-1:0]         out_start_q;
  logic                         out_empty_q;
  logic                         out_ovf_q;

  logic [CW-1:0]        kc;
  logic                 in_fire;
  logic                 id_used;
  logic [LIW-1:0]       id_l;
  logic [LIW-1:0]       sel;
  logic [LW-1:0]        len_sel;
  logic                 full;
  logic                 empty_any;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [AW-1:0]        ram_raddr;
  logic signed [DW-1:0] rdata;
  logic [LW-1:0]        pos_m;
  logic [LW-1:0]        pos_next;
  logic                 step_last;
  logic [DW-1:0]        width;
  logic [LIW-1:0]       cap_idx;

  logic                 tv   [2*NL-1];
  logic signed [DW-1:0] tval [2*NL-1];
  logic [LIW-1:0]       tidx [2*NL-1];
  logic signed [DW-1:0] min_val;
  logic [LIW-1:0]       min_idx;

  always_comb begin
    if (list_count_q == '0) begin
      kc = CW'(1);
    end else if (32'(list_count_q) > MAX_LISTS) begin
      kc = CW'(MAX_LISTS);
    end else begin
      kc = CW'(list_count_q);
    end
  end

  assign in_i.ready = cmd_i.accept;
  assign in_fire    = in_i.valid && cmd_i.accept;
  assign id_used    = 32'(in_i.list_id) < 32'(kc);
  assign id_l       = LIW'(in_i.list_id);

  // Min over list heads; left child wins ties so the lowest list index is kept.
  always_comb begin
    for (int i = 0; i < NL; i++) begin
      tv[NL-1+i]   = 1'b0;
      tval[NL-1+i] = '0;
      tidx[NL-1+i] = LIW'(i);
    end
    for (int i = 0; i < MAX_LISTS; i++) begin
      tv[NL-1+i]   = 32'(i) < 32'(kc);
      tval[NL-1+i] = head_q[i];
    end
    for (int n = NL - 2; n >= 0; n--) begin
      if (tv[2*n+2] && (!tv[2*n+1] || (tval[2*n+2] < tval[2*n+1]))) begin
        tv[n]   = tv[2*n+2];
        tval[n] = tval[2*n+2];
        tidx[n] = tidx[2*n+2];
      end else begin
        tv[n]   = tv[2*n+1];
        tval[n] = tval[2*n+1];
        tidx[n] = tidx[2*n+1];
      end
    end
  end

  assign min_val = tval[0];
  assign min_idx = tidx[0];

  assign sel     = cmd_i.accept ? id_l : min_idx;
  assign len_sel = len_q[sel];
  assign full    = 32'(len_sel) >= MAX_LEN;

  always_comb begin
    empty_any = 1'b0;
    for (int i = 0; i < MAX_LISTS; i++) begin
      if ((32'(i) < 32'(kc)) && (len_q[i] == '0)) empty_any = 1'b1;
    end
  end

  assign pos_m     = pos_q[min_idx];
  assign pos_next  = LW'(pos_m + LW'(1));
  assign step_last = ({1'b0, pos_m} + (LW+1)'(1)) >= {1'b0, len_sel};
  assign width     = max_q - min_val;

  assign ram_we    = in_fire && id_used && !full;
  assign ram_waddr = AW'(AW'(id_l) * AW'(MAX_LEN)) + AW'(len_sel);
  assign ram_raddr = cmd_i.step ? AW'(AW'(min_idx) * AW'(MAX_LEN)) + AW'(pos_next)
                                : AW'(AW'(idx_q) * AW'(MAX_LEN));

  smrk_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (in_i.elem_value),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  assign cap_idx = cmd_i.fetch ? m_q : idx_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.init_wr || cmd_i.fetch) begin
      head_q[cap_idx] <= rdata;
    end
    if (cmd_i.finish) begin
      out_width_q <= empty_any ? '0 : best_w_q[DW-1:0];
      out_start_q <= empty_any ? '0 : best_s_q;
      out_empty_q <= empty_any;
      out_ovf_q   <= drop_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_count_q <= smrk_pkg::COUNT_W'(1);
      for (int i = 0; i < MAX_LISTS; i++) begin
        len_q[i] <= '0;
        pos_q[i] <= '0;
      end
      max_q       <= smrk_pkg::INT_MIN;
      best_w_q    <= '1;
      best_s_q    <= '0;
      drop_q      <= 1'b0;
      idx_q       <= '0;
      m_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) list_count_q <= cfg_wdata_i;

      if (in_fire && id_used) begin
        if (full) begin
          drop_q <= 1'b1;
        end else begin
          len_q[id_l] <= LW'(len_sel + LW'(1));
        end
      end

      if (cmd_i.init_start) idx_q <= '0;
      if (cmd_i.init_wr) idx_q <= LIW'(idx_q + LIW'(1));

      if ((cmd_i.init_wr || cmd_i.fetch) && (rdata > max_q)) max_q <= rdata;

      if (cmd_i.step) begin
        m_q <= min_idx;
        if ({1'b0, width} < best_w_q) begin
          best_w_q <= {1'b0, width};
          best_s_q <= min_val;
        end
        if (!step_last) pos_q[min_idx] <= pos_next;
      end

      if (cmd_i.finish) begin
        for (int i = 0; i < MAX_LISTS; i++) begin
          len_q[i] <= '0;
          pos_q[i] <= '0;
        end
        max_q       <= smrk_pkg::INT_MIN;
        best_w_q    <= '1;
        best_s_q    <= '0;
        drop_q      <= 1'b0;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.range_width = out_width_q;
  assign out_o.range_start = out_start_q;
  assign out_o.empty_list  = out_empty_q;
  assign out_o.overflowed  = out_ovf_q;

  assign status_o.in_fire   = in_fire;
  assign status_o.in_last   = in_i.set_done;
  assign status_o.empty_any = empty_any;
  assign status_o.init_last = 32'(idx_q) == (32'(kc) - 1);
  assign status_o.step_last = step_last;
  assign status_o.out_free  = !out_valid_q || out_o.ready;

endmodule

// ----- design/smallest_range_k_sorted_lists.sv -----
// Top level: smallest range covering k sorted lists.
// Loading: one word per cycle, in the load state only. Search after the last word: a check
// state, a head read and capture per list, then a merge step and a fetch per step, the
// final step without fetch (one RAM read port); a finish state (held while an older result
// word still waits), result valid next. An empty list skips the search: check goes straight
// to finish. Next set may load while the result word waits. Async reset clears lengths,
// best range, flags, list_count = 1; value RAM is not cleared and needs no clearing pass.
module smallest_range_k_sorted_lists #(
  parameter int MAX_LISTS = smrk_pkg::MAX_LISTS,
  parameter int MAX_LEN   = smrk_pkg::MAX_LEN
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [smrk_pkg::COUNT_W-1:0] cfg_wdata_i,
  smrk_in_if.sink                      in_i,
  smrk_out_if.source                   out_o
);

  smrk_pkg::smrk_cmd_t    cmd;
  smrk_pkg::smrk_status_t status;

  smrk_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .cmd_o    (cmd)
  );

  smrk_datapath #(
    .MAX_LISTS (MAX_LISTS),
    .MAX_LEN   (MAX_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_i),
    .out_o       (out_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd.accept, cmd.init_start, cmd.init_rd, cmd.init_wr, cmd.step, cmd.fetch,
              cmd.finish}))
    else $error("more than one command active");

  a_init_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.init_rd |=> cmd.init_wr)
    else $error("head capture did not follow head read");

  a_finish_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.finish |=> out_o.valid)
    else $error("finish did not present a result word");

  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.empty_list) |-> (out_o.range_width == '0 && out_o.range_start == '0))
    else $error("empty-list result carries nonzero range");

endmodule

// ----- test/smrk_range_checker.sv -----
`timescale 1ns / 1ps
// Checker: rebuilds each loaded set from observed words, predicts its range word and compares.
module smrk_range_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [smrk_pkg::COUNT_W-1:0] cfg_wdata_i,
  smrk_in_if                           in_mon_i,
  smrk_out_if                          out_mon_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam int DATA_W    = smrk_pkg::DATA_W;
  localparam int COUNT_W   = smrk_pkg::COUNT_W;
  localparam int MAX_LISTS = smrk_pkg::MAX_LISTS;
  localparam int MAX_LEN   = smrk_pkg::MAX_LEN;
  localparam logic signed [DATA_W-1:0] INT_MIN = smrk_pkg::INT_MIN;

  typedef struct packed {
    logic [DATA_W-1:0]        range_width;
    logic signed [DATA_W-1:0] range_start;
    logic                     empty_list;
    logic                     overflowed;
  } range_t;

  logic signed [DATA_W-1:0] list_vals [MAX_LISTS][MAX_LEN];
  int                       list_len  [MAX_LISTS];
  logic [COUNT_W-1:0]       count_reg;
  logic                     dropped;
  range_t                   expected_ranges [$];

  function automatic int lists_in_use();
    if (count_reg == 0) return 1;
    if (count_reg > MAX_LISTS) return MAX_LISTS;
    return int'(count_reg);
  endfunction

  // k-way merge: lowest list wins ties, strict improvement only, stop when the
  // list holding the minimum runs out
  function automatic range_t smallest_range(int k);
    range_t                   r;
    int                       pos [MAX_LISTS];
    int                       i;
    int                       m;
    logic signed [DATA_W-1:0] hi;
    logic signed [DATA_W-1:0] lo;
    logic [DATA_W-1:0]        w;
    logic [DATA_W:0]          best_w;
    logic [DATA_W-1:0]        best_s;
    r = '0;
    r.overflowed = dropped;
    for (i = 0; i < k; i++) begin
      if (list_len[i] == 0) begin
        r.empty_list = 1'b1;
        return r;
      end
    end
    hi = INT_MIN;
    for (i = 0; i < k; i++) begin
      pos[i] = 0;
      if (list_vals[i][0] > hi) hi = list_vals[i][0];
    end
    best_w = '1;
    best_s = '0;
    forever begin
      m = 0;
      lo = list_vals[0][pos[0]];
      for (i = 1; i < k; i++) begin
        if (list_vals[i][pos[i]] < lo) begin
          lo = list_vals[i][pos[i]];
          m = i;
        end
      end
      w = hi - lo;
      if ({1'b0, w} < best_w) begin
        best_w = {1'b0, w};
        best_s = lo;
      end
      if (pos[m] + 1 >= list_len[m]) break;
      pos[m]++;
      if (list_vals[m][pos[m]] > hi) hi = list_vals[m][pos[m]];
    end
    r.range_width = best_w[DATA_W-1:0];
    r.range_start = best_s;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : track
    range_t exp_r;
    range_t got_r;
    int     k;
    int     i;
    if (!rst_ni) begin
      count_reg = COUNT_W'(1);
      dropped = 1'b0;
      for (i = 0; i < MAX_LISTS; i++) list_len[i] = 0;
      expected_ranges.delete();
      fail_count_o = 0;
      pending_o = 0;
    end else begin
      if (cfg_we_i) count_reg = cfg_wdata_i;
      if (in_mon_i.valid && in_mon_i.ready) begin
        k = lists_in_use();
        if (in_mon_i.list_id < k) begin
          if (list_len[in_mon_i.list_id] < MAX_LEN) begin
            list_vals[in_mon_i.list_id][list_len[in_mon_i.list_id]] = in_mon_i.elem_value;
            list_len[in_mon_i.list_id]++;
          end else begin
            dropped = 1'b1;
          end
        end
        if (in_mon_i.set_done) begin
          expected_ranges.insert(expected_ranges.size(), smallest_range(k));
          for (i = 0; i < MAX_LISTS; i++) list_len[i] = 0;
          dropped = 1'b0;
        end
      end
      if (out_mon_i.valid && out_mon_i.ready) begin
        got_r.range_width = out_mon_i.range_width;
        got_r.range_start = out_mon_i.range_start;
        got_r.empty_list  = out_mon_i.empty_list;
        got_r.overflowed  = out_mon_i.overflowed;
        if (expected_ranges.size() == 0) begin
          $display("%0t: result word with none expected: width=%h start=%h empty=%b ovf=%b",
                   $time, got_r.range_width, got_r.range_start, got_r.empty_list,
                   got_r.overflowed);
          fail_count_o++;
        end else begin
          exp_r = expected_ranges.pop_front();
          if (exp_r !== got_r) begin
            $display("%0t: mismatch: expected width=%h start=%h empty=%b ovf=%b,",
                     $time, exp_r.range_width, exp_r.range_start, exp_r.empty_list,
                     exp_r.overflowed,
                     " actual width=%h start=%h empty=%b ovf=%b",
                     got_r.range_width, got_r.range_start,
                     got_r.empty_list, got_r.overflowed);
            fail_count_o++;
          end
        end
      end
      pending_o = expected_ranges.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// Testbench top: drives directed and random list sets with random idling and gives the verdict.
module tb_top;

  localparam int DATA_W    = smrk_pkg::DATA_W;
  localparam int COUNT_W   = smrk_pkg::COUNT_W;
  localparam int LIST_ID_W = smrk_pkg::LIST_ID_W;
  localparam int MAX_LISTS = smrk_pkg::MAX_LISTS;
  localparam int MAX_LEN   = smrk_pkg::MAX_LEN;
  localparam logic signed [DATA_W-1:0] INT_MIN = smrk_pkg::INT_MIN;
  localparam logic signed [DATA_W-1:0] INT_MAX = smrk_pkg::INT_MAX;

  typedef enum int {VAL_WIDE, VAL_CLOSE, VAL_EXTREME} val_mode_e;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 12;
  localparam int PHASE_WORDS = 108;
  localparam logic [COUNT_W-1:0] PHASE_COUNTS [PHASES] =
    '{4'd1, 4'd8, 4'd3, 4'd0, 4'd15, 4'd5, 4'd2, 4'd9, 4'd7, 4'd4, 4'd6, 4'd12};
  localparam logic signed [DATA_W-1:0] EXTREMES [7] =
    '{INT_MIN, INT_MIN + 1, -32'sd1, 32'sd0, 32'sd1, INT_MAX - 1, INT_MAX};

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we;
  logic [COUNT_W-1:0] cfg_wdata;
  int                 send_idle;
  int                 recv_idle;
  int                 words_sent;
  int                 cycle_count;
  int                 fail_count;
  int                 pending;

  smrk_in_if  in_bus ();
  smrk_out_if out_bus ();

  smallest_range_k_sorted_lists DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_bus),
    .out_o       (out_bus)
  );

  smrk_range_checker range_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .in_mon_i     (in_bus),
    .out_mon_i    (out_bus),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_bus.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // entered and left at a falling edge
  task automatic push_word(input int id, input logic signed [DATA_W-1:0] val,
                           input logic done);
    while ($urandom_range(0, 99) < send_idle) begin
      in_bus.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_bus.valid      <= 1'b1;
    in_bus.list_id    <= LIST_ID_W'(id);
    in_bus.elem_value <= val;
    in_bus.set_done   <= done;
    @(posedge clk_i);
    while (!in_bus.ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic drain(input int settle);
    in_bus.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (settle) @(negedge clk_i);
  endtask

  task automatic write_count(input int c);
    drain(8);
    cfg_we    <= 1'b1;
    cfg_wdata <= COUNT_W'(c);
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_lists(input int k, input int max_len, input val_mode_e mode,
                            input bit make_empty, input bit unsort, input bit noise,
                            input bit overfill);
    logic signed [DATA_W-1:0] vals [MAX_LISTS][MAX_LEN+8];
    logic signed [DATA_W-1:0] tmp;
    int     cnt   [MAX_LISTS];
    int     taken [MAX_LISTS];
    longint v;
    longint base;
    int     e;
    int     l;
    int     j;
    int     a;
    int     n;
    int     total;
    bit     end_noise;
    base = longint'($signed($urandom));
    e = make_empty ? $urandom_range(0, k - 1) : -1;
    for (l = 0; l < MAX_LISTS; l++) begin
      cnt[l] = (l < k && l != e) ? $urandom_range(1, max_len) : 0;
      taken[l] = 0;
    end
    if (overfill && e < 0) cnt[$urandom_range(0, k - 1)] = MAX_LEN + $urandom_range(1, 3);
    for (l = 0; l < k; l++) begin
      if (mode == VAL_WIDE) v = longint'($signed($urandom));
      else v = base + $urandom_range(0, 16);
      a = $urandom_range(0, 6);
      for (j = 0; j < cnt[l]; j++) begin
        if (mode == VAL_EXTREME) begin
          vals[l][j] = EXTREMES[a];
          if (a < 6 && $urandom_range(0, 3) == 0) a++;
        end else begin
          if (v > longint'(INT_MAX)) v = longint'(INT_MAX);
          if (v < longint'(INT_MIN)) v = longint'(INT_MIN);
          vals[l][j] = v[DATA_W-1:0];
          v += (mode == VAL_WIDE) ? $urandom_range(0, 32'h1FFF_FFFF) : $urandom_range(0, 4);
        end
      end
    end
    if (unsort) begin
      l = $urandom_range(0, k - 1);
      if (l == e) l = (l + 1) % k;
      if (l != e) begin
        if (cnt[l] < 2) begin
          cnt[l] = 2;
          vals[l][1] = $signed($urandom);
        end else begin
          tmp = vals[l][0];
          vals[l][0] = vals[l][cnt[l]-1];
          vals[l][cnt[l]-1] = tmp;
        end
      end
    end
    total = 0;
    for (l = 0; l < k; l++) total += cnt[l];
    end_noise = (k < MAX_LISTS) && (total == 0 || (noise && $urandom_range(0, 1) == 1));
    for (n = 0; n < total; n++) begin
      do l = $urandom_range(0, k - 1); while (taken[l] >= cnt[l]);
      if (noise && k < MAX_LISTS && $urandom_range(0, 3) == 0)
        push_word($urandom_range(k, MAX_LISTS - 1), $urandom, 1'b0);
      push_word(l, vals[l][taken[l]], (n == total - 1) && !end_noise);
      taken[l]++;
    end
    if (end_noise) push_word($urandom_range(k, MAX_LISTS - 1), $urandom, 1'b1);
    words_sent += total;
  endtask

  initial begin
    int        p;
    int        k;
    int        l;
    int        phase_start;
    bit        first;
    bit        ovf;
    val_mode_e mode;
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_wdata         = '0;
    in_bus.valid      = 1'b0;
    in_bus.list_id    = '0;
    in_bus.elem_value = '0;
    in_bus.set_done   = 1'b0;
    words_sent        = 0;
    send_idle         = 33;
    recv_idle         = 56;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // count after reset is 1: id 1 is ignored
    push_word(0, 7, 1'b0);
    push_word(1, 9, 1'b1);
    write_count(2);
    push_word(0, INT_MIN, 1'b0);
    push_word(1, INT_MAX, 1'b1);
    push_word(0, 5, 1'b0);
    push_word(1, 5, 1'b0);
    push_word(1, 7, 1'b1);
    push_word(0, 3, 1'b1);
    push_word(5, 111, 1'b0);
    push_word(0, 1, 1'b0);
    push_word(1, 2, 1'b0);
    push_word(7, -5, 1'b1);
    push_word(0, 10, 1'b0);
    push_word(0, 2, 1'b0);
    push_word(1, 4, 1'b0);
    push_word(1, 9, 1'b1);
    write_count(0);
    push_word(0, -1, 1'b0);
    push_word(3, 4, 1'b1);
    write_count(15);
    for (l = 0; l < MAX_LISTS; l++) push_word(l, EXTREMES[l % 7], l == MAX_LISTS - 1);

    for (p = 0; p < PHASES; p++) begin
      write_count(int'(PHASE_COUNTS[p]));
      k = (PHASE_COUNTS[p] == 0) ? 1 :
          (PHASE_COUNTS[p] > MAX_LISTS) ? MAX_LISTS : int'(PHASE_COUNTS[p]);
      phase_start = words_sent;
      first = 1'b1;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if (words_sent < 433) begin
          send_idle = 33;
          recv_idle = 56;
        end else if (words_sent < 866) begin
          send_idle = 56;
          recv_idle = 33;
        end else begin
          send_idle = 0;
          recv_idle = 0;
        end
        mode = val_mode_e'($urandom_range(0, 2));
        ovf = (first && (p == 1 || p == 3 || p == 6)) || $urandom_range(0, 99) == 0;
        send_lists(k, ($urandom_range(0, 7) == 0) ? 12 : 4, mode,
                   !ovf && $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                   $urandom_range(0, 5) == 0, ovf);
        first = 1'b0;
      end
    end

    drain(40);
    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
